// ===== sv/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// Shared widths, opcodes, sequencer states and the result record for the
// handle slot table.
// ----------------------------------------------------------------------------
package hst_pkg;

	// fixed field widths of the request and result beats
	localparam int OP_W     = 3;
	localparam int HANDLE_W = 6;
	localparam int OBJ_W    = 32;

	// default table geometry
	localparam int SLOT_COUNT_DEF = 64;
	localparam int REF_WIDTH_DEF  = 32;

	// request opcodes
	localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd2;
	localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd3;
	localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_SCAN,
		ST_DONE
	} state_t;

	// one result beat
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [OBJ_W-1:0]    obj;
		logic                fault;
	} rsp_t;

endpackage

// ===== sv/hst_slot_ram.sv =====
// ----------------------------------------------------------------------------
// hst_slot_ram
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hst_slot_ram #(
	parameter int SLOT_COUNT = hst_pkg::SLOT_COUNT_DEF,
	parameter int REF_WIDTH  = hst_pkg::REF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(SLOT_COUNT)-1:0] waddr,
	input  logic [REF_WIDTH-1:0]          wdata,
	input  logic [$clog2(SLOT_COUNT)-1:0] raddr,
	output logic [REF_WIDTH-1:0]          rdata
);
	import hst_pkg::*;

	logic [REF_WIDTH-1:0] mem_q [SLOT_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/hst_ctrl.sv =====
// ----------------------------------------------------------------------------
// hst_ctrl
// Request sequencer: clearing pass, single-slot access and the linear slot
// scan; the single-slot checks and the scan share one slot-word comparator.
// ----------------------------------------------------------------------------
module hst_ctrl #(
	parameter int SLOT_COUNT = hst_pkg::SLOT_COUNT_DEF,
	parameter int REF_WIDTH  = hst_pkg::REF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [hst_pkg::OP_W-1:0]      opcode,
	input  logic [hst_pkg::HANDLE_W-1:0]  handle_in,
	input  logic [hst_pkg::OBJ_W-1:0]     object_ref,
	output logic                          req_stall,
	input  logic                          out_free,
	output logic                          done,
	output hst_pkg::rsp_t                 res,
	output logic                          mem_we,
	output logic [$clog2(SLOT_COUNT)-1:0] mem_waddr,
	output logic [REF_WIDTH-1:0]          mem_wdata,
	output logic [$clog2(SLOT_COUNT)-1:0] mem_raddr,
	input  logic [REF_WIDTH-1:0]          mem_rdata
);
	import hst_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [REF_WIDTH-1:0] REF_INV  = '1;

	state_t               state_q, state_d;
	logic [OP_W-1:0]      op_q;
	logic [IDX_W-1:0]     addr_q;
	logic [REF_WIDTH-1:0] ref_q;
	logic [IDX_W-1:0]     cnt_q, cnt_d;
	logic [IDX_W-1:0]     tag_q, tag_d;
	logic                 tag_vld_q, tag_vld_d;
	rsp_t                 res_q, res_d;
	logic                 load;

	logic [REF_WIDTH-1:0] key;
	logic                 h_ok, ref_ok;
	logic [REF_WIDTH-1:0] cmp_key;
	logic                 hit, rd_zero, rd_inv;

	// request decode
	assign key    = REF_WIDTH'(object_ref);
	assign h_ok   = (handle_in != '0) && (32'(handle_in) < 32'(SLOT_COUNT));
	assign ref_ok = (key != '0) && (key != REF_INV);

	// shared slot-word comparator
	assign cmp_key = (op_q == OP_ALLOC) ? '0 : ref_q;
	assign hit     = (mem_rdata == cmp_key);
	assign rd_zero = (mem_rdata == '0);
	assign rd_inv  = (mem_rdata == REF_INV);

	assign req_stall = (state_q != ST_IDLE);
	assign res       = res_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			tag_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			tag_vld_q <= tag_vld_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			op_q   <= opcode;
			addr_q <= IDX_W'(handle_in);
			ref_q  <= key;
		end
		tag_q <= tag_d;
		res_q <= res_d;
	end

	// next state, memory control and result
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		tag_d     = cnt_q;
		tag_vld_d = 1'b0;
		res_d     = res_q;
		load      = 1'b0;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = (state_q == ST_SCAN) ? cnt_q : addr_q;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				if (cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					load  = 1'b1;
					res_d = '0;
					cnt_d = IDX_W'(1);
					unique case (opcode)
						OP_ALLOC, OP_REVERSE: begin
							state_d = ref_ok ? ST_SCAN : ST_DONE;
						end
						OP_FREE, OP_LOOKUP, OP_INVALIDATE: begin
							state_d = h_ok ? ST_READ : ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				unique case (op_q)
					OP_FREE: begin
						res_d.obj = OBJ_W'(mem_rdata);
						mem_we    = 1'b1;
					end
					OP_LOOKUP: begin
						if (!rd_inv) begin
							res_d.obj = OBJ_W'(mem_rdata);
						end
					end
					OP_INVALIDATE: begin
						if (rd_zero) begin
							res_d.fault = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = REF_INV;
						end
					end
					default: begin
					end
				endcase
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				// one read issued per cycle, compared in the cycle after it is issued
				tag_vld_d = 1'b1;
				cnt_d     = (cnt_q == LAST_IDX) ? cnt_q : cnt_q + 1'b1;
				if (tag_vld_q && hit) begin
					res_d.handle = HANDLE_W'(tag_q);
					if (op_q == OP_ALLOC) begin
						mem_we    = 1'b1;
						mem_waddr = tag_q;
						mem_wdata = ref_q;
					end
					tag_vld_d = 1'b0;
					state_d   = ST_DONE;
				end else if (tag_vld_q && (tag_q == LAST_IDX)) begin
					tag_vld_d = 1'b0;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/handle_slot_table.sv =====
// ----------------------------------------------------------------------------
// handle_slot_table
// Table of object-reference slots with allocate, free, lookup, invalidate
// and reverse lookup requests, one request at a time.
// ----------------------------------------------------------------------------
// states: free, lookup and invalidate pass ST_READ, ST_CHECK, then ST_DONE;
//   allocate and reverse lookup scan the slot memory one read per cycle from
//   slot 1 on; rejected requests go straight from ST_IDLE to ST_DONE
// requests: one at a time, the next one is taken after the result beat leaves
//   the sequencer, so a scan also holds off the next request until it ends
// reset: a clearing pass zeroes every slot; req_stall stays high until it ends
module handle_slot_table #(
	parameter int SLOT_COUNT = hst_pkg::SLOT_COUNT_DEF,
	parameter int REF_WIDTH  = hst_pkg::REF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [hst_pkg::OP_W-1:0]     opcode,
	input  logic [hst_pkg::HANDLE_W-1:0] handle_in,
	input  logic [hst_pkg::OBJ_W-1:0]    object_ref,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [hst_pkg::HANDLE_W-1:0] handle_out,
	output logic [hst_pkg::OBJ_W-1:0]    object_out,
	output logic                         fault
);
	import hst_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [REF_WIDTH-1:0] mem_wdata, mem_rdata;
	logic                 done, out_free;
	rsp_t                 res;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;

	hst_slot_ram #(
		.SLOT_COUNT (SLOT_COUNT),
		.REF_WIDTH  (REF_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hst_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.REF_WIDTH  (REF_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.opcode     (opcode),
		.handle_in  (handle_in),
		.object_ref (object_ref),
		.req_stall  (req_stall),
		.out_free   (out_free),
		.done       (done),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign handle_out = rsp_q.handle;
	assign object_out = rsp_q.obj;
	assign fault      = rsp_q.fault;

endmodule

// ===== sv/hst_checker.sv =====
// ----------------------------------------------------------------------------
// hst_checker
// Port-level checks on the handle slot table, bound to the top level.
// ----------------------------------------------------------------------------
module hst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic [hst_pkg::OP_W-1:0]     opcode,
	input logic [hst_pkg::HANDLE_W-1:0] handle_in,
	input logic [hst_pkg::OBJ_W-1:0]    object_ref,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [hst_pkg::HANDLE_W-1:0] handle_out,
	input logic [hst_pkg::OBJ_W-1:0]    object_out,
	input logic                         fault
);
	import hst_pkg::*;

	// a stalled request beat holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(opcode)
			&& $stable(handle_in) && $stable(object_ref))
		else $error("request beat changed while stalled");

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(handle_out)
			&& $stable(object_out) && $stable(fault))
		else $error("result beat changed while stalled");

	// one request at a time: an accepted beat closes the request side
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open right after a request beat");

	// a fault comes with no handle and no reference
	a_fault_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fault |-> handle_out == '0 && object_out == '0)
		else $error("fault beat carries a handle or reference");

	// a handle result carries no reference and no fault
	a_handle_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && handle_out != '0 |-> object_out == '0 && !fault)
		else $error("handle beat carries a reference or fault");

endmodule

bind handle_slot_table hst_checker u_hst_checker (.*);
